FILE: rtl/bss_pkg.sv
// bss_pkg: shared types and constants for the byte substring search block
// holds the default sizes, the queue item type and the register index codes
// no dependencies
`timescale 1ns / 1ps

package bss_pkg;

    // default sizes
    localparam int MAX_NEEDLE_DEF    = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int POS_OUT_W  = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int NEEDLE_W   = 128;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2
    } t_cfg_reg;

    // one haystack item as it waits in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_item;

endpackage

FILE: rtl/bss_queue.sv
// bss_queue: short item queue between the accepting front and the scan back end
// depends on bss_pkg for the item type
`timescale 1ns / 1ps

module bss_queue #(
    parameter int DEPTH = bss_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bss_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output bss_pkg::t_item o_item,
    input  logic           i_pop
);
    import bss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

endmodule

FILE: rtl/bss_scan.sv
// bss_scan: byte window, parallel needle compare, first match tracking and result register
// depends on bss_pkg for widths and the item type
`timescale 1ns / 1ps

module bss_scan #(
    parameter int MAX_NEEDLE    = bss_pkg::MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = bss_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [8*MAX_NEEDLE-1:0]           i_needle,
    input  logic [bss_pkg::LEN_W-1:0]         i_needle_len,
    input  logic                              i_valid,
    input  bss_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bss_pkg::POS_OUT_W-1:0]     o_m_tdata,
    output logic                              o_m_tuser
);
    import bss_pkg::*;

    localparam int LW = $clog2(MAX_NEEDLE + 1);
    localparam int CW = POSITION_BITS + 1;

    logic [BYTE_W-1:0]        r_win [MAX_NEEDLE];
    logic [BYTE_W-1:0]        win_next [MAX_NEEDLE];
    logic [CW-1:0]            r_cnt;
    logic                     r_match;
    logic [POSITION_BITS-1:0] r_first;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [POS_OUT_W-1:0]     r_out_pos;

    logic [LW-1:0]            len_eff;
    logic [MAX_NEEDLE:0]      cand;
    logic [CW-1:0]            cnt_inc;
    logic [CW-1:0]            start_full;
    logic [POSITION_BITS-1:0] start_sat;
    logic                     hit;
    logic                     match_new;
    logic [POSITION_BITS-1:0] first_new;
    logic                     out_free;
    logic                     take;

    // lengths above the window act as a full window
    assign len_eff = (i_needle_len > LEN_W'(MAX_NEEDLE)) ? LW'(MAX_NEEDLE)
                                                         : i_needle_len[LW-1:0];

    // window after the new byte shifts in, entry 0 newest
    always_comb begin
        win_next[0] = i_item.data;
        for (int k = 1; k < MAX_NEEDLE; k++) begin
            win_next[k] = r_win[k-1];
        end
    end

    // one candidate match per needle length, all compared in parallel
    always_comb begin
        cand[0] = 1'b0;
        for (int l = 1; l <= MAX_NEEDLE; l++) begin
            cand[l] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (win_next[l-1-j] != i_needle[8*j +: 8]) begin
                    cand[l] = 1'b0;
                end
            end
        end
    end

    // saturating byte count and start index of a match ending here
    always_comb begin
        cnt_inc    = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
        start_full = cnt_inc - CW'(len_eff);
        start_sat  = start_full[CW-1] ? '1 : start_full[POSITION_BITS-1:0];
        hit        = (len_eff != '0) && !r_match && (cnt_inc >= CW'(len_eff))
                     && cand[len_eff];
        match_new  = r_match | hit;
        first_new  = hit ? start_sat : r_first;
    end

    // a last item waits until the result register is free
    assign out_free = !r_out_valid || i_m_tready;
    assign take     = i_valid && (!i_item.last || out_free);
    assign o_pop    = take;

    // stream state, cleared after each last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_NEEDLE; k++) begin
                r_win[k] <= '0;
            end
            r_cnt   <= '0;
            r_match <= 1'b0;
            r_first <= '0;
        end else if (take) begin
            if (i_item.last) begin
                for (int k = 0; k < MAX_NEEDLE; k++) begin
                    r_win[k] <= '0;
                end
                r_cnt   <= '0;
                r_match <= 1'b0;
                r_first <= '0;
            end else begin
                for (int k = 0; k < MAX_NEEDLE; k++) begin
                    r_win[k] <= win_next[k];
                end
                r_cnt   <= cnt_inc;
                r_match <= match_new;
                r_first <= first_new;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, empty needle matches at the start
    always_ff @(posedge i_clk) begin
        if (take && i_item.last) begin
            if (len_eff == '0) begin
                r_out_found <= 1'b1;
                r_out_pos   <= '0;
            end else begin
                r_out_found <= match_new;
                r_out_pos   <= match_new ? POS_OUT_W'(first_new) : '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pos;
    assign o_m_tuser  = r_out_found;

endmodule

FILE: rtl/byte_substring_search.sv
// byte_substring_search: first occurrence of a configured needle in a streamed haystack
// a result is registered once the scan back end takes its last item from the queue
// throughput: one byte per cycle unless the queue is full; all lengths compared at once
// a two-item queue lets input continue while a result waits at the output register
// reset: synchronous active low, clears config registers, result valid, window, counters and queue
`timescale 1ns / 1ps

module byte_substring_search #(
    parameter int MAX_NEEDLE    = bss_pkg::MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = bss_pkg::POSITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bss_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // haystack item stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] haystack_byte
    input  logic                             i_s_tlast,   // last_byte
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [15:0]                      o_m_tdata,   // [15:0] match_position
    output logic                             o_m_tuser    // [0] found
);
    import bss_pkg::*;

    logic [CFG_DATA_W-1:0] r_needle_low;
    logic [CFG_DATA_W-1:0] r_needle_high;
    logic [LEN_W-1:0]      r_needle_len;
    logic [NEEDLE_W-1:0]   needle_all;

    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_item  in_item;
    t_item  q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NEEDLE_LOW:  r_needle_low  <= i_cfg_data;
                CFG_NEEDLE_HIGH: r_needle_high <= i_cfg_data;
                CFG_NEEDLE_LEN:  r_needle_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign needle_all = {r_needle_high, r_needle_low};

    // front: accept items into the queue
    assign o_s_tready   = !q_full;
    assign in_item.data = i_s_tdata;
    assign in_item.last = i_s_tlast;

    bss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid && !q_full),
        .i_item  (in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // back: window compare and result
    bss_scan #(
        .MAX_NEEDLE    (MAX_NEEDLE),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_needle     (needle_all[8*MAX_NEEDLE-1:0]),
        .i_needle_len (r_needle_len),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

FILE: rtl/bss_checker.sv
// bss_checker: port level checks for byte_substring_search, bound to the top level
// no package dependencies
`timescale 1ns / 1ps

module bss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result item dropped while stalled");

    // a miss reports position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 16'd0))
        else $error("miss with nonzero position");

    // the queue only fills up behind a waiting result
    a_full_behind_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result pending");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind byte_substring_search bss_checker u_bss_checker (.*);
